FILE: hdl/ceb_pkg.sv
`default_nettype none

package ceb_pkg;

  localparam int unsigned TIME_W = 48;
  localparam int unsigned MULT_W = 7;
  localparam int unsigned SUM_W = 22;
  localparam int unsigned TYPE_SLOTS = 16;
  localparam int unsigned SUM_ENTRIES = 256;
  localparam int unsigned SUM_AW = 8;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam logic [TIME_W-1:0] REL_OFFSET = 48'd1000;
  localparam logic [31:0] NO_REF_SEEN = 32'd30000;

  typedef enum logic [1:0] {
    OP_HIT   = 2'd0,
    OP_MAP   = 2'd1,
    OP_FLUSH = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    CFG_TIME_GATE = 3'd0,
    CFG_FOLD      = 3'd1,
    CFG_REF_TYPE  = 3'd2,
    CFG_RUN_UNIT  = 3'd3,
    CFG_REF_UNIT  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [23:0] time_gate;
    logic [6:0]  fold;
    logic [3:0]  ref_type;
    logic [31:0] run_unit;
    logic [31:0] ref_unit;
  } cfg_t;

  typedef struct packed {
    op_e         op;
    logic [3:0]  module_number;
    logic [3:0]  channel_number;
    logic [47:0] hit_time;
    logic [15:0] hit_energy;
    logic [15:0] hit_integral;
    logic [3:0]  hit_flags;
    logic [3:0]  map_type;
    logic [4:0]  map_index;
  } cmd_t;

  typedef struct packed {
    logic [47:0] hit_time;
    logic [3:0]  module_number;
    logic [3:0]  channel_number;
    logic [15:0] hit_energy;
    logic [15:0] hit_integral;
    logic [3:0]  hit_flags;
  } win_t;

  typedef struct packed {
    logic [3:0] det_type;
    logic [4:0] det_index;
  } map_t;

  typedef struct packed {
    logic [31:0] event_number;
    logic [3:0]  det_type;
    logic [4:0]  det_index;
    logic [23:0] relative_time;
    logic [21:0] energy_sum;
    logic [21:0] integral_sum;
    logic [3:0]  out_flags;
    logic [6:0]  type_multiplicity;
    logic [6:0]  event_multiplicity;
    logic [47:0] run_time;
    logic [31:0] reference_time;
    logic        last_of_event;
  } res_t;

endpackage

`default_nettype wire

FILE: hdl/coincidence_event_builder_top.sv
`default_nettype none

// sequence: a hit that joins the open window goes through look-up and check; a flush or a
//   closing hit walks the window to count, and for a kept event runs the shared bit-serial
//   divider and walks the window again to emit one result beat per mapped hit
// flow: the sequencer takes a new item only once the last is done; a 2-entry command queue
//   takes items while the sequencer is evaluating; results cannot be stalled by the receiver
// reset: asynchronous active low; empties the window and queue, clears the channel table
//   valid bits, reference stamp and event count, and loads register defaults

module coincidence_event_builder_top #(
  parameter int unsigned MAX_HITS    = 63,
  parameter int unsigned NUM_TYPES   = 15,
  parameter int unsigned MAX_INDEX   = 16,
  parameter int unsigned MAP_ENTRIES = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  operation_i,
  input  wire logic [3:0]  module_number_i,
  input  wire logic [3:0]  channel_number_i,
  input  wire logic [47:0] hit_time_i,
  input  wire logic [15:0] hit_energy_i,
  input  wire logic [15:0] hit_integral_i,
  input  wire logic [3:0]  hit_flags_i,
  input  wire logic [3:0]  map_type_i,
  input  wire logic [4:0]  map_index_i,
  output logic             result_valid_o,
  output logic [31:0]      event_number_o,
  output logic [3:0]       det_type_o,
  output logic [4:0]       det_index_o,
  output logic [23:0]      relative_time_o,
  output logic [21:0]      energy_sum_o,
  output logic [21:0]      integral_sum_o,
  output logic [3:0]       out_flags_o,
  output logic [6:0]       type_multiplicity_o,
  output logic [6:0]       event_multiplicity_o,
  output logic [47:0]      run_time_o,
  output logic [31:0]      reference_time_o,
  output logic             last_of_event_o
);
  import ceb_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd_in;
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;
  res_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.time_gate <= 24'd100;
      cfg_q.fold      <= 7'd1;
      cfg_q.ref_type  <= 4'd0;
      cfg_q.run_unit  <= 32'd1;
      cfg_q.ref_unit  <= 32'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TIME_GATE: cfg_q.time_gate <= cfg_data_i[23:0];
        CFG_FOLD:      cfg_q.fold      <= cfg_data_i[6:0];
        CFG_REF_TYPE:  cfg_q.ref_type  <= cfg_data_i[3:0];
        CFG_RUN_UNIT:  cfg_q.run_unit  <= cfg_data_i;
        CFG_REF_UNIT:  cfg_q.ref_unit  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cmd_in = '{op: op_e'(operation_i), module_number: module_number_i,
                    channel_number: channel_number_i, hit_time: hit_time_i,
                    hit_energy: hit_energy_i, hit_integral: hit_integral_i,
                    hit_flags: hit_flags_i, map_type: map_type_i, map_index: map_index_i};

  ceb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_in_i    (cmd_in),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  ceb_back #(
    .MAX_HITS    (MAX_HITS),
    .NUM_TYPES   (NUM_TYPES),
    .MAX_INDEX   (MAX_INDEX),
    .MAP_ENTRIES (MAP_ENTRIES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_valid_o (result_valid_o),
    .res_o       (res)
  );

  assign event_number_o       = res.event_number;
  assign det_type_o           = res.det_type;
  assign det_index_o          = res.det_index;
  assign relative_time_o      = res.relative_time;
  assign energy_sum_o         = res.energy_sum;
  assign integral_sum_o       = res.integral_sum;
  assign out_flags_o          = res.out_flags;
  assign type_multiplicity_o  = res.type_multiplicity;
  assign event_multiplicity_o = res.event_multiplicity;
  assign run_time_o           = res.run_time;
  assign reference_time_o     = res.reference_time;
  assign last_of_event_o      = res.last_of_event;

endmodule

`default_nettype wire

FILE: hdl/ceb_front.sv
`default_nettype none

module ceb_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire ceb_pkg::cmd_t cmd_in_i,
  output logic               cmd_valid_o,
  output ceb_pkg::cmd_t      cmd_o,
  input  wire logic          cmd_pop_i
);
  import ceb_pkg::*;

  localparam int unsigned QAW = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            q_mem [QUEUE_DEPTH];
  logic [QAW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCW-1:0]  cnt_q;
  logic            known_op;
  logic            push;
  logic            pop;

  // unused operation code is taken and dropped here
  always_comb begin
    case (cmd_in_i.op)
      OP_HIT, OP_MAP, OP_FLUSH: known_op = 1'b1;
      default: known_op = 1'b0;
    endcase
  end

  assign busy        = (cnt_q == QCW'(QUEUE_DEPTH));
  assign push        = start && !busy && known_op;
  assign pop         = cmd_pop_i && (cnt_q != '0);
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cmd_in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= QAW'(wr_ptr_q + 1'b1);
      end
      if (pop) begin
        rd_ptr_q <= QAW'(rd_ptr_q + 1'b1);
      end
      cnt_q <= QCW'(cnt_q + QCW'(push) - QCW'(pop));
    end
  end

endmodule

`default_nettype wire

FILE: hdl/ceb_div.sv
`default_nettype none

module ceb_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        go_i,
  input  wire logic [47:0] dividend_i,
  input  wire logic [31:0] divisor_i,
  output logic             done_o,
  output logic [47:0]      quotient_o
);
  import ceb_pkg::*;

  logic        busy_q;
  logic [5:0]  cnt_q;
  logic [32:0] rem_q;
  logic [47:0] quo_q;
  logic [31:0] div_q;
  logic        done_q;
  logic [32:0] shifted;
  logic        take;

  // restoring division, one quotient bit per cycle
  assign shifted    = {rem_q[31:0], quo_q[47]};
  assign take       = (shifted >= {1'b0, div_q});
  assign done_o     = done_q;
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
      rem_q  <= '0;
      quo_q  <= '0;
      div_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= '0;
        quo_q  <= dividend_i;
        div_q  <= (divisor_i == '0) ? 32'd1 : divisor_i;
      end else if (busy_q) begin
        rem_q <= take ? 33'(shifted - {1'b0, div_q}) : shifted;
        quo_q <= {quo_q[46:0], take};
        cnt_q <= 6'(cnt_q + 1'b1);
        if (cnt_q == 6'd47) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/ceb_back.sv
`default_nettype none

module ceb_back #(
  parameter int unsigned MAX_HITS    = 63,
  parameter int unsigned NUM_TYPES   = 15,
  parameter int unsigned MAX_INDEX   = 16,
  parameter int unsigned MAP_ENTRIES = 256
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire ceb_pkg::cfg_t cfg_i,
  input  wire logic          cmd_valid_i,
  input  wire ceb_pkg::cmd_t cmd_i,
  output logic               cmd_pop_o,
  output logic               res_valid_o,
  output ceb_pkg::res_t      res_o
);
  import ceb_pkg::*;

  localparam int unsigned WIN_AW    = $clog2(MAX_HITS + 1);
  localparam int unsigned WIN_DEPTH = 2 ** WIN_AW;
  localparam int unsigned CNT_W     = $clog2(MAX_HITS + 2);
  localparam int unsigned MAP_AW    = $clog2(MAP_ENTRIES);

  typedef enum logic [4:0] {
    ST_IDLE, ST_HIT_LOOK, ST_HIT_CHECK, ST_EVAL,
    ST_A_WIN, ST_A_MAP, ST_A_SUM, ST_A_ACC,
    ST_DECIDE, ST_DIV_RUN, ST_DIV_REF,
    ST_B_WIN, ST_B_MAP, ST_B_SUM, ST_B_OUT,
    ST_DROP, ST_D_WIN, ST_D_MAP, ST_D_CHK
  } state_e;

  state_e state_q;

  // window buffer, circular
  win_t              win_mem [WIN_DEPTH];
  win_t              win_rd_q;
  logic [WIN_AW-1:0] win_ra, win_wa;
  logic              win_we;
  win_t              win_wd;

  // channel table
  map_t              map_mem [MAP_ENTRIES];
  logic [MAP_ENTRIES-1:0] map_vld_q;
  map_t              map_rd_q;
  logic              map_ok_q;
  logic [7:0]        map_addr;
  logic [MAP_AW-1:0] map_ra;
  logic              map_in_range;
  logic              map_we;
  logic [7:0]        cmd_addr;
  logic              cmd_in_range;

  // per-detector sums
  logic [2*SUM_W-1:0]   sum_mem [SUM_ENTRIES];
  logic [SUM_ENTRIES-1:0] sum_vld_q;
  logic [2*SUM_W-1:0]   sum_rd_q;
  logic                 sum_ok_q;
  logic [SUM_AW-1:0]    sum_ra, sum_wa;
  logic                 sum_we;
  logic [2*SUM_W-1:0]   sum_wd;
  logic [2*SUM_W-1:0]   sum_old;

  // decoded table entry
  logic       dec_ok;
  logic [3:0] dec_t;
  logic [4:0] dec_ix;
  logic [4:0] dec_ix_m1;
  logic [4:0] cur_ix_m1;

  // window bookkeeping
  logic [WIN_AW-1:0] head_q;
  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  pos_q;
  logic [CNT_W-1:0]  pos_nx;
  logic [CNT_W-1:0]  last_pos_q;
  logic [TIME_W-1:0] head_time_q;
  logic [TIME_W-1:0] stamp_q;
  logic              seen_q;
  logic [31:0]       evt_cnt_q;
  logic              src_flush_q;
  cmd_t              cmd_q;
  logic              hit_ref_q;

  // event evaluation
  logic [MULT_W-1:0] tc_q [TYPE_SLOTS];
  logic [MULT_W-1:0] mult_q;
  logic              found_q;
  logic [TIME_W-1:0] start_q;
  win_t              cur_q;
  logic [3:0]        cur_t_q;
  logic [4:0]        cur_ix_q;
  logic [47:0]       run_q;
  logic [31:0]       refv_q;
  logic [23:0]       rel_q;
  res_t              res_q;
  logic              res_valid_q;

  logic              fits;
  logic [TIME_W-1:0] gate_diff;
  logic              append;
  logic              dec_is_ref;
  logic [49:0]       rel_full;

  logic              div_go;
  logic [47:0]       div_dividend;
  logic [31:0]       div_divisor;
  logic              div_done;
  logic [47:0]       div_quo;
  logic              need_ref_div;

  ceb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (div_go),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // ---------------- combinational control ----------------
  assign cmd_pop_o    = (state_q == ST_IDLE) && cmd_valid_i;
  assign cmd_addr     = {cmd_i.module_number, cmd_i.channel_number};
  assign cmd_in_range = ({1'b0, cmd_addr} < 9'(MAP_ENTRIES));
  assign map_addr     = (state_q == ST_IDLE) ? cmd_addr
                                             : {win_rd_q.module_number, win_rd_q.channel_number};
  assign map_in_range = ({1'b0, map_addr} < 9'(MAP_ENTRIES));
  assign map_ra       = map_addr[MAP_AW-1:0];
  assign map_we       = cmd_pop_o && (cmd_i.op == OP_MAP) && cmd_in_range;

  always_comb begin
    dec_ok = map_ok_q && (map_rd_q.det_type != '0)
          && ({1'b0, map_rd_q.det_type} <= 5'(NUM_TYPES))
          && (map_rd_q.det_index != '0)
          && ({1'b0, map_rd_q.det_index} <= 6'(MAX_INDEX));
    dec_t  = dec_ok ? map_rd_q.det_type : '0;
    dec_ix = dec_ok ? map_rd_q.det_index : '0;
  end

  assign dec_is_ref = (cfg_i.ref_type != '0) && (dec_t == cfg_i.ref_type);
  assign dec_ix_m1  = 5'(dec_ix - 5'd1);
  assign cur_ix_m1  = 5'(cur_ix_q - 5'd1);
  assign sum_ra     = {dec_t, dec_ix_m1[3:0]};
  assign sum_wa     = {cur_t_q, cur_ix_m1[3:0]};
  assign sum_old    = sum_ok_q ? sum_rd_q : '0;
  assign sum_we     = (state_q == ST_A_ACC);
  assign sum_wd     = {SUM_W'(sum_old[2*SUM_W-1:SUM_W] + SUM_W'(cur_q.hit_energy)),
                       SUM_W'(sum_old[SUM_W-1:0] + SUM_W'(cur_q.hit_integral))};

  assign win_ra    = WIN_AW'(head_q + pos_q[WIN_AW-1:0]);
  assign win_wa    = WIN_AW'(head_q + count_q[WIN_AW-1:0]);
  assign win_wd    = '{hit_time: cmd_q.hit_time, module_number: cmd_q.module_number,
                       channel_number: cmd_q.channel_number, hit_energy: cmd_q.hit_energy,
                       hit_integral: cmd_q.hit_integral, hit_flags: cmd_q.hit_flags};
  assign gate_diff = TIME_W'(cmd_q.hit_time - head_time_q);
  // a hit earlier than the window start counts as inside the gate
  assign fits      = (count_q <= CNT_W'(MAX_HITS))
                  && ((cmd_q.hit_time < head_time_q) || (gate_diff < TIME_W'(cfg_i.time_gate)));
  assign append    = (count_q == '0) ? !hit_ref_q : fits;
  assign win_we    = (state_q == ST_HIT_CHECK) && append;
  assign pos_nx    = CNT_W'(pos_q + 1'b1);

  assign rel_full  = 50'({2'b00, cur_q.hit_time} + {2'b00, REL_OFFSET} - {2'b00, start_q});

  assign need_ref_div = (cfg_i.ref_type != '0) && seen_q && (head_time_q >= stamp_q);
  assign div_go       = ((state_q == ST_DECIDE) && (mult_q >= cfg_i.fold))
                     || ((state_q == ST_DIV_RUN) && div_done && need_ref_div);
  assign div_dividend = (state_q == ST_DECIDE) ? head_time_q : 48'(head_time_q - stamp_q);
  assign div_divisor  = (state_q == ST_DECIDE) ? cfg_i.run_unit : cfg_i.ref_unit;

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // ---------------- memories ----------------
  always_ff @(posedge clk_i) begin
    if (win_we) begin
      win_mem[win_wa] <= win_wd;
    end
    win_rd_q <= win_mem[win_ra];
  end

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[cmd_addr[MAP_AW-1:0]] <= '{det_type: cmd_i.map_type, det_index: cmd_i.map_index};
    end
    map_rd_q <= map_mem[map_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_vld_q <= '0;
      map_ok_q  <= 1'b0;
    end else begin
      if (map_we) begin
        map_vld_q[cmd_addr[MAP_AW-1:0]] <= 1'b1;
      end
      map_ok_q <= map_in_range && map_vld_q[map_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_we) begin
      sum_mem[sum_wa] <= sum_wd;
    end
    sum_rd_q <= sum_mem[sum_ra];
  end

  // sums of an event start from zero: all valid bits drop at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_vld_q <= '0;
      sum_ok_q  <= 1'b0;
    end else begin
      if (state_q == ST_EVAL) begin
        sum_vld_q <= '0;
      end else if (sum_we) begin
        sum_vld_q[sum_wa] <= 1'b1;
      end
      sum_ok_q <= sum_vld_q[sum_ra];
    end
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      pos_q       <= '0;
      last_pos_q  <= '0;
      head_time_q <= '0;
      stamp_q     <= '0;
      seen_q      <= 1'b0;
      evt_cnt_q   <= '0;
      src_flush_q <= 1'b0;
      cmd_q       <= '0;
      hit_ref_q   <= 1'b0;
      tc_q        <= '{default: '0};
      mult_q      <= '0;
      found_q     <= 1'b0;
      start_q     <= '0;
      cur_q       <= '0;
      cur_t_q     <= '0;
      cur_ix_q    <= '0;
      run_q       <= '0;
      refv_q      <= '0;
      rel_q       <= '0;
      res_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q <= cmd_i;
            case (cmd_i.op)
              OP_HIT: begin
                src_flush_q <= 1'b0;
                state_q     <= ST_HIT_LOOK;
              end
              OP_FLUSH: begin
                src_flush_q <= 1'b1;
                if (count_q != '0) begin
                  state_q <= ST_EVAL;
                end
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end
        ST_HIT_LOOK: begin
          hit_ref_q <= dec_is_ref;
          state_q   <= ST_HIT_CHECK;
        end
        ST_HIT_CHECK: begin
          if (count_q == '0 || fits) begin
            if (hit_ref_q) begin
              stamp_q <= cmd_q.hit_time;
              seen_q  <= 1'b1;
            end
            if (append) begin
              count_q <= CNT_W'(count_q + 1'b1);
            end
            if (count_q == '0) begin
              head_time_q <= cmd_q.hit_time;
            end
            state_q <= ST_IDLE;
          end else begin
            state_q <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          tc_q    <= '{default: '0};
          mult_q  <= '0;
          found_q <= 1'b0;
          start_q <= '0;
          pos_q   <= '0;
          state_q <= ST_A_WIN;
        end
        ST_A_WIN: state_q <= ST_A_MAP;
        ST_A_MAP: begin
          cur_q   <= win_rd_q;
          state_q <= ST_A_SUM;
        end
        ST_A_SUM: begin
          cur_t_q  <= dec_t;
          cur_ix_q <= dec_ix;
          if (dec_ok) begin
            last_pos_q <= pos_q;
            if (!dec_is_ref) begin
              tc_q[dec_t] <= MULT_W'(tc_q[dec_t] + 1'b1);
              mult_q      <= MULT_W'(mult_q + 1'b1);
              if (!found_q) begin
                found_q <= 1'b1;
                start_q <= cur_q.hit_time;
              end
            end
            state_q <= ST_A_ACC;
          end else begin
            pos_q   <= pos_nx;
            state_q <= (pos_nx == count_q) ? ST_DECIDE : ST_A_WIN;
          end
        end
        ST_A_ACC: begin
          pos_q   <= pos_nx;
          state_q <= (pos_nx == count_q) ? ST_DECIDE : ST_A_WIN;
        end
        ST_DECIDE: begin
          state_q <= (mult_q < cfg_i.fold) ? ST_DROP : ST_DIV_RUN;
        end
        ST_DIV_RUN: begin
          if (div_done) begin
            run_q <= (&div_quo) ? div_quo : 48'(div_quo + 48'd1);
            if (need_ref_div) begin
              state_q <= ST_DIV_REF;
            end else begin
              refv_q  <= (cfg_i.ref_type == '0) ? 32'd0 : (!seen_q ? NO_REF_SEEN : 32'd0);
              pos_q   <= '0;
              state_q <= ST_B_WIN;
            end
          end
        end
        ST_DIV_REF: begin
          if (div_done) begin
            refv_q  <= (|div_quo[47:32]) ? 32'hFFFF_FFFF : div_quo[31:0];
            pos_q   <= '0;
            state_q <= ST_B_WIN;
          end
        end
        ST_B_WIN: state_q <= ST_B_MAP;
        ST_B_MAP: begin
          cur_q   <= win_rd_q;
          state_q <= ST_B_SUM;
        end
        ST_B_SUM: begin
          cur_t_q  <= dec_t;
          cur_ix_q <= dec_ix;
          if (rel_full[49]) begin
            rel_q <= '0;
          end else if (|rel_full[48:24]) begin
            rel_q <= 24'hFF_FFFF;
          end else begin
            rel_q <= rel_full[23:0];
          end
          if (dec_ok) begin
            state_q <= ST_B_OUT;
          end else if (pos_nx == count_q) begin
            evt_cnt_q <= 32'(evt_cnt_q + 1'b1);
            count_q   <= '0;
            state_q   <= src_flush_q ? ST_IDLE : ST_HIT_CHECK;
          end else begin
            pos_q   <= pos_nx;
            state_q <= ST_B_WIN;
          end
        end
        ST_B_OUT: begin
          res_valid_q             <= 1'b1;
          res_q.event_number      <= evt_cnt_q;
          res_q.det_type          <= cur_t_q;
          res_q.det_index         <= cur_ix_q;
          res_q.relative_time     <= rel_q;
          res_q.energy_sum        <= sum_old[2*SUM_W-1:SUM_W];
          res_q.integral_sum      <= sum_old[SUM_W-1:0];
          res_q.out_flags         <= cur_q.hit_flags;
          res_q.type_multiplicity <= (cur_t_q == cfg_i.ref_type) ? '0 : tc_q[cur_t_q];
          res_q.event_multiplicity <= mult_q;
          res_q.run_time          <= run_q;
          res_q.reference_time    <= refv_q;
          res_q.last_of_event     <= (pos_q == last_pos_q);
          if (pos_nx == count_q) begin
            evt_cnt_q <= 32'(evt_cnt_q + 1'b1);
            count_q   <= '0;
            state_q   <= src_flush_q ? ST_IDLE : ST_HIT_CHECK;
          end else begin
            pos_q   <= pos_nx;
            state_q <= ST_B_WIN;
          end
        end
        ST_DROP: begin
          head_q  <= WIN_AW'(head_q + 1'b1);
          count_q <= CNT_W'(count_q - 1'b1);
          pos_q   <= '0;
          if (count_q == CNT_W'(1)) begin
            state_q <= src_flush_q ? ST_IDLE : ST_HIT_CHECK;
          end else begin
            state_q <= ST_D_WIN;
          end
        end
        ST_D_WIN: state_q <= ST_D_MAP;
        ST_D_MAP: begin
          cur_q   <= win_rd_q;
          state_q <= ST_D_CHK;
        end
        ST_D_CHK: begin
          // reference hits reaching the head only load the stamp
          if (dec_is_ref) begin
            stamp_q <= cur_q.hit_time;
            seen_q  <= 1'b1;
            head_q  <= WIN_AW'(head_q + 1'b1);
            count_q <= CNT_W'(count_q - 1'b1);
            if (count_q == CNT_W'(1)) begin
              state_q <= src_flush_q ? ST_IDLE : ST_HIT_CHECK;
            end else begin
              state_q <= ST_D_WIN;
            end
          end else begin
            head_time_q <= cur_q.hit_time;
            state_q     <= src_flush_q ? ST_EVAL : ST_HIT_CHECK;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_HITS + 1))
    else $error("window over capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> $past(state_q) == ST_B_OUT)
    else $error("result beat outside output step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV_RUN || state_q == ST_DIV_REF))
    else $error("divider finished while not awaited");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EVAL |-> count_q != '0)
    else $error("evaluating an empty window");

endmodule

`default_nettype wire

FILE: verif/tb.sv
`default_nettype none

module tb;
  import ceb_pkg::*;

  localparam logic [47:0] TICK_MAX = 48'hFFFF_FFFF_FFFF;
  localparam int unsigned SETTLE_CYCLES = 6000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        start = 1'b0;
  logic        busy;
  cmd_t        cur_cmd = '0;
  logic        result_valid_o;
  res_t        got;

  coincidence_event_builder_top u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .start(start), .busy(busy),
    .operation_i(cur_cmd.op), .module_number_i(cur_cmd.module_number),
    .channel_number_i(cur_cmd.channel_number), .hit_time_i(cur_cmd.hit_time),
    .hit_energy_i(cur_cmd.hit_energy), .hit_integral_i(cur_cmd.hit_integral),
    .hit_flags_i(cur_cmd.hit_flags), .map_type_i(cur_cmd.map_type),
    .map_index_i(cur_cmd.map_index),
    .result_valid_o(result_valid_o),
    .event_number_o(got.event_number), .det_type_o(got.det_type),
    .det_index_o(got.det_index), .relative_time_o(got.relative_time),
    .energy_sum_o(got.energy_sum), .integral_sum_o(got.integral_sum),
    .out_flags_o(got.out_flags), .type_multiplicity_o(got.type_multiplicity),
    .event_multiplicity_o(got.event_multiplicity), .run_time_o(got.run_time),
    .reference_time_o(got.reference_time), .last_of_event_o(got.last_of_event)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // builder model state
  logic [23:0] gate_r = 24'd100;
  logic [6:0]  fold_r = 7'd1;
  logic [3:0]  ref_type_r = '0;
  logic [31:0] run_unit_r = 32'd1;
  logic [31:0] ref_unit_r = 32'd1;
  map_t        chan_map [256];
  win_t        open_win [$];
  logic [47:0] ref_stamp = '0;
  bit          ref_seen = 1'b0;
  logic [31:0] evt_count = '0;

  res_t        expected_hits [$];
  cmd_t        pending_cmds [$];
  logic [47:0] now_tick = '0;

  int unsigned n_checked = 0, n_errors = 0, n_cmds = 0, n_events = 0;
  bit          took = 1'b0;
  int unsigned gap_left = 0, burst_left = 0;

  function automatic logic [3:0] map_lookup(input logic [3:0] m, input logic [3:0] c,
                                            output logic [4:0] ix);
    map_t e;
    e = chan_map[{m, c}];
    ix = '0;
    if (e.det_type == 0 || e.det_type > 15 || e.det_index == 0 || e.det_index > 16)
      return '0;
    ix = e.det_index;
    return e.det_type;
  endfunction

  function automatic bit is_ref_chan(input logic [3:0] m, input logic [3:0] c);
    logic [4:0] ix;
    return ref_type_r != 0 && map_lookup(m, c, ix) == ref_type_r;
  endfunction

  // drop the head hit, then consume any reference hits that become head
  function automatic void drop_window_head();
    void'(open_win.pop_front());
    while (open_win.size() > 0 &&
           is_ref_chan(open_win[0].module_number, open_win[0].channel_number)) begin
      ref_stamp = open_win[0].hit_time;
      ref_seen = 1'b1;
      void'(open_win.pop_front());
    end
  endfunction

  function automatic bit build_event();
    int unsigned mult, tcount [16], last;
    logic [31:0] esum [16][32], isum [16][32];
    logic [63:0] first_t, run, refv, dv, rel;
    logic [3:0]  t;
    logic [4:0]  ix;
    bit          found;
    res_t        r;
    mult = 0;
    found = 1'b0;
    first_t = '0;
    foreach (tcount[k]) tcount[k] = 0;
    foreach (esum[a, b]) begin
      esum[a][b] = '0;
      isum[a][b] = '0;
    end
    foreach (open_win[n]) begin
      t = map_lookup(open_win[n].module_number, open_win[n].channel_number, ix);
      if (t != 0 && t != ref_type_r) begin
        tcount[t]++;
        mult++;
        if (!found) begin
          first_t = open_win[n].hit_time;
          found = 1'b1;
        end
      end
    end
    if (mult < fold_r) return 1'b0;
    foreach (open_win[n]) begin
      t = map_lookup(open_win[n].module_number, open_win[n].channel_number, ix);
      if (t != 0) begin
        esum[t][ix] += open_win[n].hit_energy;
        isum[t][ix] += open_win[n].hit_integral;
      end
    end
    dv = (run_unit_r == 0) ? 64'd1 : 64'(run_unit_r);
    run = 64'd1 + 64'(open_win[0].hit_time) / dv;
    if (run > 64'(TICK_MAX)) run = 64'(TICK_MAX);
    if (ref_type_r == 0) refv = 0;
    else if (!ref_seen) refv = 64'(NO_REF_SEEN);
    else if (open_win[0].hit_time < ref_stamp) refv = 0;
    else begin
      dv = (ref_unit_r == 0) ? 64'd1 : 64'(ref_unit_r);
      refv = 64'(open_win[0].hit_time - ref_stamp) / dv;
      if (refv > 64'hFFFF_FFFF) refv = 64'hFFFF_FFFF;
    end
    last = expected_hits.size();
    foreach (open_win[n]) begin
      t = map_lookup(open_win[n].module_number, open_win[n].channel_number, ix);
      if (t != 0) begin
        rel = 64'(open_win[n].hit_time) + 64'(REL_OFFSET);
        rel = (rel < first_t) ? 64'd0 : rel - first_t;
        if (rel > 64'hFF_FFFF) rel = 64'hFF_FFFF;
        r.event_number = evt_count;
        r.det_type = t;
        r.det_index = ix;
        r.relative_time = rel[23:0];
        r.energy_sum = esum[t][ix][21:0];
        r.integral_sum = isum[t][ix][21:0];
        r.out_flags = open_win[n].hit_flags;
        r.type_multiplicity = 7'(tcount[t]);
        r.event_multiplicity = 7'(mult);
        r.run_time = run[47:0];
        r.reference_time = refv[31:0];
        r.last_of_event = 1'b0;
        expected_hits.push_back(r);
      end
    end
    if (expected_hits.size() > last) expected_hits[$].last_of_event = 1'b1;
    evt_count++;
    n_events++;
    open_win.delete();
    return 1'b1;
  endfunction

  function automatic void join_window(input cmd_t c);
    win_t w;
    w.hit_time = c.hit_time;
    w.module_number = c.module_number;
    w.channel_number = c.channel_number;
    w.hit_energy = c.hit_energy;
    w.hit_integral = c.hit_integral;
    w.hit_flags = c.hit_flags;
    open_win.push_back(w);
    if (is_ref_chan(c.module_number, c.channel_number)) begin
      ref_stamp = c.hit_time;
      ref_seen = 1'b1;
    end
  endfunction

  function automatic void predict_cmd(input cmd_t c);
    map_t e;
    if (c.op == OP_MAP) begin
      e.det_type = c.map_type;
      e.det_index = c.map_index;
      chan_map[{c.module_number, c.channel_number}] = e;
      return;
    end
    if (c.op == OP_FLUSH) begin
      while (open_win.size() > 0) begin
        if (build_event()) break;
        drop_window_head();
      end
      return;
    end
    if (c.op != OP_HIT) return;
    forever begin
      if (open_win.size() == 0) begin
        if (is_ref_chan(c.module_number, c.channel_number)) begin
          ref_stamp = c.hit_time;
          ref_seen = 1'b1;
        end else begin
          join_window(c);
        end
        return;
      end
      if (open_win.size() <= 63 && (c.hit_time < open_win[0].hit_time ||
          c.hit_time - open_win[0].hit_time < 48'(gate_r))) begin
        join_window(c);
        return;
      end
      if (!build_event()) drop_window_head();
    end
  endfunction

  // accept beats and check results
  always @(posedge clk_i) begin
    res_t want;
    took <= start && !busy;
    if (rst_ni && start && !busy) begin
      predict_cmd(cur_cmd);
      n_cmds++;
    end
    if (rst_ni && result_valid_o) begin
      if (expected_hits.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result beat: %p", got);
      end else begin
        want = expected_hits.pop_front();
        n_checked++;
        if (got !== want) begin
          n_errors++;
          if (n_errors <= 10) $display("mismatch\n  exp %p\n  got %p", want, got);
        end
      end
    end
  end

  // sender: bursts of beats with random gaps
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (start && !took) begin
      start <= 1'b1;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      start <= 1'b0;
    end else if (pending_cmds.size() > 0) begin
      cur_cmd <= pending_cmds.pop_front();
      start <= 1'b1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 12);
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      start <= 1'b0;
    end
  end

  task automatic push_map(input logic [3:0] m, input logic [3:0] c,
                          input logic [3:0] t, input logic [4:0] ix);
    cmd_t k;
    k = '0;
    k.op = OP_MAP;
    k.module_number = m;
    k.channel_number = c;
    k.map_type = t;
    k.map_index = ix;
    k.hit_time = {$urandom, $urandom};
    pending_cmds.push_back(k);
  endtask

  task automatic push_hit(input logic [3:0] m, input logic [3:0] c, input logic [47:0] dt,
                          input logic [15:0] en, input logic [15:0] ig,
                          input logic [3:0] fl);
    cmd_t k;
    k = '0;
    k.op = OP_HIT;
    now_tick = (TICK_MAX - now_tick < dt) ? TICK_MAX : now_tick + dt;
    k.module_number = m;
    k.channel_number = c;
    k.hit_time = now_tick;
    k.hit_energy = en;
    k.hit_integral = ig;
    k.hit_flags = fl;
    k.map_type = 4'($urandom);
    k.map_index = 5'($urandom);
    pending_cmds.push_back(k);
  endtask

  task automatic push_op(input op_e o);
    cmd_t k;
    k = '0;
    k.op = o;
    k.module_number = 4'($urandom);
    k.channel_number = 4'($urandom);
    pending_cmds.push_back(k);
  endtask

  task automatic push_random(input int unsigned count, input int unsigned dt_max);
    int unsigned pick;
    cmd_t k;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        if ($urandom_range(0, 4) == 0)
          push_map(4'($urandom), 4'($urandom), 4'($urandom), 5'($urandom));
        else
          push_map(4'($urandom_range(0, 3)), 4'($urandom), 4'($urandom_range(1, 15)),
                   5'($urandom_range(1, 16)));
      end else if (pick < 12) begin
        push_op(OP_FLUSH);
      end else if (pick < 14) begin
        k = '0;
        k.op = op_e'(2'd3);
        k.hit_time = {$urandom, $urandom};
        pending_cmds.push_back(k);
      end else if (pick < 22) begin
        push_hit(4'($urandom), 4'($urandom), 48'($urandom_range(0, dt_max)),
                 16'($urandom), 16'($urandom), 4'($urandom));
      end else begin
        push_hit(4'($urandom_range(0, 3)), 4'($urandom), 48'($urandom_range(0, dt_max)),
                 16'($urandom), 16'($urandom), 4'($urandom));
      end
    end
    push_op(OP_FLUSH);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_TIME_GATE: gate_r = val[23:0];
      CFG_FOLD:      fold_r = val[6:0];
      CFG_REF_TYPE:  ref_type_r = val[3:0];
      CFG_RUN_UNIT:  run_unit_r = val;
      CFG_REF_UNIT:  ref_unit_r = val;
      default: ;
    endcase
  endtask

  // sender holds off until every result is back and the block has settled
  task automatic drain();
    wait (pending_cmds.size() == 0 && !start);
    wait (expected_hits.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [23:0] g, input logic [6:0] f, input logic [3:0] rt,
                          input logic [31:0] ru, input logic [31:0] fu);
    write_reg(CFG_TIME_GATE, 32'(g));
    write_reg(CFG_FOLD, 32'(f));
    write_reg(CFG_REF_TYPE, 32'(rt));
    write_reg(CFG_RUN_UNIT, ru);
    write_reg(CFG_REF_UNIT, fu);
  endtask

  initial begin
    foreach (chan_map[a]) chan_map[a] = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset settings, table corners, sums of one detector, odd ops
    push_map(4'd0, 4'd0, 4'd1, 5'd1);
    push_map(4'd0, 4'd1, 4'd1, 5'd16);
    push_map(4'd15, 4'd15, 4'd15, 5'd16);
    push_map(4'd0, 4'd2, 4'd2, 5'd0);
    push_map(4'd0, 4'd3, 4'd15, 5'd31);
    push_map(4'd1, 4'd0, 4'd0, 5'd5);
    push_op(OP_FLUSH);
    push_hit(4'd0, 4'd0, 48'd0, 16'hFFFF, 16'hFFFF, 4'hF);
    push_hit(4'd0, 4'd0, 48'd10, 16'hFFFF, 16'h0000, 4'h0);
    push_hit(4'd15, 4'd15, 48'd99, 16'h0001, 16'hFFFF, 4'h5);
    push_hit(4'd0, 4'd2, 48'd1, 16'h1234, 16'h4321, 4'hA);
    push_hit(4'd0, 4'd1, 48'd100, 16'h0000, 16'h0000, 4'h3);
    push_op(op_e'(2'd3));
    push_hit(4'd1, 4'd0, 48'd5000, 16'h0000, 16'h0000, 4'h0);
    push_op(OP_FLUSH);
    push_hit(4'd0, 4'd3, 48'd50, 16'h00FF, 16'h00FF, 4'h1);
    push_hit(4'd0, 4'd1, 48'd0, 16'hFF00, 16'hFF00, 4'h2);
    push_op(OP_FLUSH);
    drain();

    // every hit closes the previous window; empty events allowed
    set_regs(24'd0, 7'd0, 4'd0, 32'd1, 32'd1);
    push_hit(4'd1, 4'd0, 48'd3, 16'h0, 16'h0, 4'h0);
    push_random(40, 50);
    drain();

    // reference timing with scaled units
    set_regs(24'd400, 7'd2, 4'd3, 32'd7, 32'd3);
    push_map(4'd2, 4'd0, 4'd3, 5'd1);
    push_map(4'd2, 4'd1, 4'd4, 5'd2);
    push_hit(4'd2, 4'd0, 48'd10, 16'h10, 16'h10, 4'h1);
    push_hit(4'd2, 4'd1, 48'd1000, 16'h10, 16'h10, 4'h1);
    push_hit(4'd2, 4'd0, 48'd20, 16'h10, 16'h10, 4'h1);
    push_hit(4'd2, 4'd1, 48'd20, 16'h10, 16'h10, 4'h1);
    push_random(80, 150);
    drain();

    // register extremes: widest gate, full window needed, zero divisor
    set_regs(24'hFF_FFFF, 7'd64, 4'd15, 32'hFFFF_FFFF, 32'd0);
    push_random(30, 3);
    push_random(50, 2);
    push_hit(4'd0, 4'd0, 48'hFF_FFFF, 16'h1, 16'h1, 4'h1);
    push_op(OP_FLUSH);
    drain();

    // timestamps near the top of the range
    set_regs(24'd2000, 7'd1, 4'd15, 32'd1000, 32'd1);
    push_hit(4'd15, 4'd15, 48'hFFFF_0000_0000 - now_tick, 16'h2, 16'h2, 4'h2);
    push_random(60, 300);
    push_hit(4'd0, 4'd0, TICK_MAX, 16'h3, 16'h3, 4'h3);
    push_hit(4'd0, 4'd1, 48'd0, 16'h3, 16'h3, 4'h3);
    push_op(OP_FLUSH);
    drain();

    $display("covered %0d commands, %0d events built, %0d result beats checked",
             n_cmds, n_events, n_checked);
    $display("gate, fold, reference and divisor settings swept incl. extremes");
    if (n_errors == 0 && expected_hits.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d errors, %0d results missing", n_errors, expected_hits.size());
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #60000000;
    $display("timeout");
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
hdl/ceb_pkg.sv
hdl/ceb_front.sv
hdl/ceb_div.sv
hdl/ceb_back.sv
hdl/coincidence_event_builder_top.sv
verif/tb.sv
